// File: hw/rtl/fcr_pkg.sv
// ----------------------------------------------------------------------------
// fcr_pkg: shared definitions for the convolution reverb
// Widths, register indexes, gain limits and the divider handshake types.
// ----------------------------------------------------------------------------
package fcr_pkg;

	localparam int MAX_TAPS    = 4096;
	localparam int SAMPLE_W    = 16;
	localparam int COEF_IDX_W  = 12;
	localparam int TAP_COUNT_W = 13;
	localparam int GAIN_W      = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_DATA_W   = 48;
	localparam int MUL_BW      = GAIN_W + 2;
	localparam int ACC_LO_W    = 22;
	localparam int Q15_SHIFT   = 15;
	localparam int QUO_W       = 15;
	localparam int REM_W       = 30;

	localparam int GAIN_MIN    = 3277;
	localparam int GAIN_MAX    = 32768;
	localparam int COEF_SCALE  = 32767;
	localparam int DIV_LIMIT   = 32768 * COEF_SCALE;

	localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN  = 2'd2;

	localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 13'd4096;
	localparam logic [GAIN_W-1:0]      DRY_GAIN_RESET  = 16'd32768;
	localparam logic [GAIN_W-1:0]      WET_GAIN_RESET  = 16'd22938;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_COEF   = 1'b1;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	typedef struct packed {
		logic start;
		logic neg;
	} div_req_t;

	typedef struct packed {
		logic                       done;
		logic signed [SAMPLE_W-1:0] q;
	} div_rsp_t;

	function automatic logic [GAIN_W:0] clamp_gain(input logic [GAIN_W-1:0] g);
		logic [GAIN_W:0] r;
		if ({1'b0, g} < (GAIN_W+1)'(GAIN_MIN)) begin
			r = (GAIN_W+1)'(GAIN_MIN);
		end else if ({1'b0, g} > (GAIN_W+1)'(GAIN_MAX)) begin
			r = (GAIN_W+1)'(GAIN_MAX);
		end else begin
			r = {1'b0, g};
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/fcr_mul.sv
// ----------------------------------------------------------------------------
// fcr_mul: shared signed multiplier
// One registered signed product per cycle, used for the taps and the gains.
// ----------------------------------------------------------------------------
module fcr_mul #(
	parameter int AW = 23
) (
	input  logic                                 clk,
	input  logic signed [AW-1:0]                 a,
	input  logic signed [fcr_pkg::MUL_BW-1:0]    b,
	output logic signed [AW+fcr_pkg::MUL_BW-1:0] p
);

	logic signed [AW+fcr_pkg::MUL_BW-1:0] p_s1;

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

	assign p = p_s1;

endmodule

// File: hw/rtl/fcr_div.sv
// ----------------------------------------------------------------------------
// fcr_div: scaling divider with saturation
// Divides a magnitude by 32768 * 32767 with a shift and a folded compare step,
// and returns the signed, saturated 16-bit sample.
// ----------------------------------------------------------------------------
module fcr_div #(
	parameter int MagW = 62
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fcr_pkg::div_req_t   req,
	input  logic [MagW-1:0]     mag,
	output fcr_pkg::div_rsp_t   rsp
);

	logic [MagW-1:0]                     scaled;
	logic                                busy_q;
	logic                                done_q;
	logic                                neg_q;
	logic                                sat_q;
	logic [fcr_pkg::QUO_W-1:0]           hi_q;
	logic [fcr_pkg::QUO_W-1:0]           lo_q;
	logic [fcr_pkg::QUO_W:0]             fold;
	logic [fcr_pkg::QUO_W-1:0]           quo_q;
	logic signed [fcr_pkg::SAMPLE_W-1:0] quo_s;

	assign scaled = mag >> fcr_pkg::Q15_SHIFT;
	assign fold   = {1'b0, hi_q} + {1'b0, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= req.start;
			done_q <= busy_q;
		end
	end

	// With the magnitude split as hi * 32768 + lo, the quotient by 32767 is hi
	// plus the number of times 32767 fits into hi + lo, which is at most two.
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.neg;
			sat_q <= scaled >= MagW'(fcr_pkg::DIV_LIMIT);
			hi_q  <= scaled[fcr_pkg::REM_W-1:fcr_pkg::QUO_W];
			lo_q  <= scaled[fcr_pkg::QUO_W-1:0];
		end
		if (busy_q) begin
			if (fold >= (fcr_pkg::QUO_W+1)'(2 * fcr_pkg::COEF_SCALE)) begin
				quo_q <= hi_q + fcr_pkg::QUO_W'(2);
			end else if (fold >= (fcr_pkg::QUO_W+1)'(fcr_pkg::COEF_SCALE)) begin
				quo_q <= hi_q + fcr_pkg::QUO_W'(1);
			end else begin
				quo_q <= hi_q;
			end
		end
	end

	assign quo_s    = signed'({1'b0, quo_q});
	assign rsp.done = done_q;
	assign rsp.q    = sat_q ? (neg_q ? fcr_pkg::SAMPLE_MIN : fcr_pkg::SAMPLE_MAX)
	                        : (neg_q ? -quo_s : quo_s);

endmodule

// File: hw/rtl/fir_convolution_reverb.sv
// ----------------------------------------------------------------------------
// fir_convolution_reverb: FIR convolution reverb
// Direct-form FIR over a circular delay line, mixed with the dry input.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  s_*      in         s_tvalid / s_tready  tdata: sample_in, coef_index,
//                                           coef_value; tuser: req_type
//  m_*      out        m_tvalid / m_tready  tdata: sample_out
//  cfg_*    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A coefficient word is written on acceptance and the input stays ready. A sample
// word is taken in ST_IDLE, runs one tap a cycle through the shared multiplier,
// drains it, forms the gain products and the sum, scales in the divider and
// loads the output register in ST_OUT; the input is not ready until ST_IDLE.
// After reset the delay line is cleared, one entry a cycle, through all MaxTaps entries
// (4096 by default); no input word is taken meanwhile, configuration is.
// A stalled output holds the finished sample in its register.
// ----------------------------------------------------------------------------
module fir_convolution_reverb #(
	parameter int MaxTaps = fcr_pkg::MAX_TAPS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// sample_in [15:0], coef_index [27:16], coef_value [43:28], zero [47:44]
	input  logic [fcr_pkg::IN_DATA_W-1:0]      s_tdata,
	// req_type [0]
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// sample_out [15:0]
	output logic [fcr_pkg::SAMPLE_W-1:0]       m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fcr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fcr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AddrW = (MaxTaps > 1) ? $clog2(MaxTaps) : 1;
	localparam int TapW  = $clog2(MaxTaps + 1);
	localparam int AccW  = 32 + TapW;
	localparam int MulAW = (AccW - fcr_pkg::ACC_LO_W > 23) ? AccW - fcr_pkg::ACC_LO_W : 23;
	localparam int PrdW  = MulAW + fcr_pkg::MUL_BW;
	localparam int NumW  = ((AccW + 16 > 47) ? AccW + 16 : 47) + 1;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_MAC   = 4'd2;
	localparam logic [3:0] ST_MLO   = 4'd3;
	localparam logic [3:0] ST_MHI   = 4'd4;
	localparam logic [3:0] ST_MDRY  = 4'd5;
	localparam logic [3:0] ST_DRY   = 4'd6;
	localparam logic [3:0] ST_SUM   = 4'd7;
	localparam logic [3:0] ST_ABS   = 4'd8;
	localparam logic [3:0] ST_DIV   = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	logic [3:0]                          state_q;
	logic [AddrW-1:0]                    clr_q;
	logic [fcr_pkg::TAP_COUNT_W-1:0]     tap_count_q;
	logic [fcr_pkg::GAIN_W-1:0]          dry_gain_q;
	logic [fcr_pkg::GAIN_W-1:0]          wet_gain_q;
	logic [AddrW-1:0]                    wr_idx_q;
	logic [TapW-1:0]                     taps_q;
	logic [AddrW-1:0]                    idx_q;
	logic [TapW-1:0]                     cnt_q;
	logic                                v_s1;
	logic                                v_s2;
	logic signed [AccW-1:0]              acc_q;
	logic signed [fcr_pkg::SAMPLE_W-1:0] x_q;
	logic [fcr_pkg::GAIN_W:0]            dg_q;
	logic [fcr_pkg::GAIN_W:0]            wg_q;
	logic signed [NumW-1:0]              wet_q;
	logic signed [NumW-1:0]              dry_q;
	logic signed [NumW-1:0]              num_q;
	logic                                m_tvalid_q;
	logic [fcr_pkg::SAMPLE_W-1:0]        m_tdata_q;

	logic signed [fcr_pkg::SAMPLE_W-1:0] hist_mem [MaxTaps];
	logic signed [fcr_pkg::SAMPLE_W-1:0] coef_mem [MaxTaps];
	logic signed [fcr_pkg::SAMPLE_W-1:0] hist_rd_q;
	logic signed [fcr_pkg::SAMPLE_W-1:0] coef_rd_q;

	logic                                req_type;
	logic signed [fcr_pkg::SAMPLE_W-1:0] sample_in;
	logic [fcr_pkg::COEF_IDX_W-1:0]      coef_index;
	logic signed [fcr_pkg::SAMPLE_W-1:0] coef_value;
	logic                                in_acc;
	logic                                smp_acc;
	logic                                coef_acc;
	logic [TapW-1:0]                     taps_eff;
	logic [AddrW-1:0]                    pos;
	logic [AddrW-1:0]                    pos_next;
	logic                                issue;
	logic signed [MulAW-1:0]             mul_a;
	logic signed [fcr_pkg::MUL_BW-1:0]   mul_b;
	logic signed [PrdW-1:0]              prod;
	logic [NumW-1:0]                     abs_mag;
	fcr_pkg::div_req_t                   div_req;
	fcr_pkg::div_rsp_t                   div_rsp;
	logic                                out_free;

	assign req_type   = s_tuser;
	assign sample_in  = s_tdata[15:0];
	assign coef_index = s_tdata[27:16];
	assign coef_value = s_tdata[43:28];

	assign s_tready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign smp_acc   = in_acc && req_type == fcr_pkg::REQ_SAMPLE;
	assign coef_acc  = in_acc && req_type == fcr_pkg::REQ_COEF;
	assign issue     = state_q == ST_MAC && cnt_q != taps_q;
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		if (tap_count_q == '0) begin
			taps_eff = TapW'(1);
		end else if (32'(tap_count_q) > MaxTaps) begin
			taps_eff = TapW'(MaxTaps);
		end else begin
			taps_eff = TapW'(tap_count_q);
		end
		if (32'(wr_idx_q) >= 32'(taps_eff)) begin
			pos = '0;
		end else begin
			pos = wr_idx_q;
		end
		if (32'(pos) + 32'd1 == 32'(taps_eff)) begin
			pos_next = '0;
		end else begin
			pos_next = pos + AddrW'(1);
		end
	end

	always_comb begin
		case (state_q)
			ST_MLO: begin
				mul_a = MulAW'(signed'({1'b0, acc_q[fcr_pkg::ACC_LO_W-1:0]}));
				mul_b = signed'({1'b0, wg_q});
			end
			ST_MHI: begin
				mul_a = MulAW'(acc_q >>> fcr_pkg::ACC_LO_W);
				mul_b = signed'({1'b0, wg_q});
			end
			ST_MDRY: begin
				mul_a = MulAW'(x_q);
				mul_b = signed'({1'b0, dg_q});
			end
			default: begin
				mul_a = MulAW'(hist_rd_q);
				mul_b = fcr_pkg::MUL_BW'(coef_rd_q);
			end
		endcase
	end

	fcr_mul #(
		.AW (MulAW)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign abs_mag       = num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);
	assign div_req.start = state_q == ST_ABS;
	assign div_req.neg   = num_q[NumW-1];

	fcr_div #(
		.MagW (NumW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.mag    (abs_mag),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			hist_mem[clr_q] <= '0;
		end else if (smp_acc) begin
			hist_mem[pos] <= sample_in;
		end
		if (coef_acc && 32'(coef_index) < MaxTaps) begin
			coef_mem[AddrW'(coef_index)] <= coef_value;
		end
		if (issue) begin
			hist_rd_q <= hist_mem[idx_q];
			coef_rd_q <= coef_mem[cnt_q[AddrW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= fcr_pkg::TAP_COUNT_RESET;
			dry_gain_q  <= fcr_pkg::DRY_GAIN_RESET;
			wet_gain_q  <= fcr_pkg::WET_GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fcr_pkg::CFG_TAP_COUNT: tap_count_q <= cfg_data[fcr_pkg::TAP_COUNT_W-1:0];
				fcr_pkg::CFG_DRY_GAIN:  dry_gain_q  <= cfg_data;
				fcr_pkg::CFG_WET_GAIN:  wet_gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			wr_idx_q   <= '0;
			cnt_q      <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AddrW'(1);
					if (clr_q == AddrW'(MaxTaps - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (smp_acc) begin
						wr_idx_q <= pos_next;
						cnt_q    <= '0;
						state_q  <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (issue) begin
						cnt_q <= cnt_q + TapW'(1);
					end else if (!v_s1 && !v_s2) begin
						state_q <= ST_MLO;
					end
				end
				ST_MLO:  state_q <= ST_MHI;
				ST_MHI:  state_q <= ST_MDRY;
				ST_MDRY: state_q <= ST_DRY;
				ST_DRY:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_ABS;
				ST_ABS:  state_q <= ST_DIV;
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (smp_acc) begin
			taps_q <= taps_eff;
			idx_q  <= pos;
			x_q    <= sample_in;
			dg_q   <= fcr_pkg::clamp_gain(dry_gain_q);
			wg_q   <= fcr_pkg::clamp_gain(wet_gain_q);
			acc_q  <= '0;
		end else begin
			if (issue) begin
				idx_q <= (idx_q == '0) ? AddrW'(taps_q - TapW'(1)) : idx_q - AddrW'(1);
			end
			if (v_s2) begin
				acc_q <= acc_q + AccW'(prod);
			end
		end
		case (state_q)
			ST_MHI:  wet_q <= NumW'(prod);
			ST_MDRY: wet_q <= wet_q + (NumW'(prod) <<< fcr_pkg::ACC_LO_W);
			ST_DRY:  dry_q <= (NumW'(prod) <<< fcr_pkg::Q15_SHIFT) - NumW'(prod);
			ST_SUM:  num_q <= wet_q + dry_q;
			ST_OUT: begin
				if (out_free) begin
					m_tdata_q <= div_rsp.q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the FIR convolution reverb
// Drives sample and coefficient words with random idling on both streams,
// predicts every output sample from a local copy of the delay line, the
// impulse response and the registers, and compares each output word in order.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_WORDS  = 12;
	localparam logic [fcr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                               clk       = 1'b0;
	logic                               arst_n    = 1'b0;
	logic                               s_tvalid  = 1'b0;
	logic                               s_tready;
	logic [fcr_pkg::IN_DATA_W-1:0]      s_tdata   = '0;
	logic                               s_tuser   = 1'b0;
	logic                               m_tvalid;
	logic                               m_tready  = 1'b0;
	logic [fcr_pkg::SAMPLE_W-1:0]       m_tdata;
	logic                               cfg_valid = 1'b0;
	logic                               cfg_ready;
	logic [fcr_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [fcr_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;

	logic signed [fcr_pkg::SAMPLE_W-1:0] dline [fcr_pkg::MAX_TAPS] = '{default: '0};
	logic signed [fcr_pkg::SAMPLE_W-1:0] ir_coef [fcr_pkg::MAX_TAPS];
	bit                                  coef_known [fcr_pkg::MAX_TAPS];
	int                                  wr_pos  = 0;
	logic [fcr_pkg::TAP_COUNT_W-1:0]     tap_reg = fcr_pkg::TAP_COUNT_RESET;
	logic [fcr_pkg::GAIN_W-1:0]          dry_reg = fcr_pkg::DRY_GAIN_RESET;
	logic [fcr_pkg::GAIN_W-1:0]          wet_reg = fcr_pkg::WET_GAIN_RESET;

	logic [fcr_pkg::SAMPLE_W-1:0] reverb_out_q [$];
	logic [fcr_pkg::SAMPLE_W-1:0] want;
	int                           mismatches   = 0;
	int                           cycles       = 0;
	int                           src_idle_pct = 17;
	int                           snk_idle_pct = 86;

	fir_convolution_reverb #(
		.MaxTaps(fcr_pkg::MAX_TAPS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (reverb_out_q.size() == 0) begin
				mismatches++;
				$display("%0t: output word %0d with none expected", $time,
					$signed(m_tdata));
			end else begin
				want = reverb_out_q.pop_front();
				if (m_tdata !== want) begin
					mismatches++;
					$display("%0t: sample_out expected %0d, got %0d", $time,
						$signed(want), $signed(m_tdata));
				end
			end
		end
	end

	function automatic int taps_in_use();
		if (tap_reg == 0) return 1;
		if (tap_reg > fcr_pkg::MAX_TAPS) return fcr_pkg::MAX_TAPS;
		return int'(tap_reg);
	endfunction

	function automatic longint gain_in_use(input logic [fcr_pkg::GAIN_W-1:0] g);
		if (g < fcr_pkg::GAIN_MIN) return fcr_pkg::GAIN_MIN;
		if (g > fcr_pkg::GAIN_MAX) return fcr_pkg::GAIN_MAX;
		return longint'(g);
	endfunction

	function automatic logic [fcr_pkg::SAMPLE_W-1:0] reverb_sample(
		input logic signed [fcr_pkg::SAMPLE_W-1:0] x);
		int     taps;
		int     pos;
		int     i;
		longint acc;
		longint num;
		longint q;
		taps = taps_in_use();
		pos  = (wr_pos >= taps) ? 0 : wr_pos;
		dline[pos] = x;
		acc = 0;
		for (i = 0; i < taps; i++) begin
			acc += longint'(dline[(pos + taps - i) % taps]) * longint'(ir_coef[i]);
		end
		wr_pos = (pos + 1 == taps) ? 0 : pos + 1;
		num = longint'(x) * gain_in_use(dry_reg) * fcr_pkg::COEF_SCALE
			+ acc * gain_in_use(wet_reg);
		q = num / (longint'(fcr_pkg::GAIN_MAX) * fcr_pkg::COEF_SCALE);
		if (q > fcr_pkg::SAMPLE_MAX) q = fcr_pkg::SAMPLE_MAX;
		if (q < fcr_pkg::SAMPLE_MIN) q = fcr_pkg::SAMPLE_MIN;
		return q[fcr_pkg::SAMPLE_W-1:0];
	endfunction

	// Half of the coefficients are small so that the output does not always saturate.
	function automatic logic [fcr_pkg::SAMPLE_W-1:0] ir_word();
		if ($urandom_range(1) != 0) return fcr_pkg::SAMPLE_W'($urandom);
		return fcr_pkg::SAMPLE_W'($urandom_range(2047)) - 16'd1024;
	endfunction

	function automatic logic [fcr_pkg::GAIN_W-1:0] random_gain();
		if ($urandom_range(3) == 0) return fcr_pkg::GAIN_W'($urandom_range(65535));
		return fcr_pkg::GAIN_W'($urandom_range(fcr_pkg::GAIN_MAX, fcr_pkg::GAIN_MIN));
	endfunction

	task automatic send_word(input logic req, input logic [fcr_pkg::SAMPLE_W-1:0] smp,
		input logic [fcr_pkg::COEF_IDX_W-1:0] cidx,
		input logic [fcr_pkg::SAMPLE_W-1:0] cval);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {4'b0000, cval, cidx, smp};
		do @(posedge clk); while (!s_tready);
		if (req == fcr_pkg::REQ_COEF) begin
			ir_coef[cidx]    = cval;
			coef_known[cidx] = 1'b1;
		end else begin
			reverb_out_q.push_back(reverb_sample(smp));
		end
	endtask

	task automatic settle(input int extra);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (reverb_out_q.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [fcr_pkg::CFG_IDX_W-1:0] idx,
		input logic [fcr_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			fcr_pkg::CFG_TAP_COUNT: begin
				tap_reg = val[fcr_pkg::TAP_COUNT_W-1:0];
			end
			fcr_pkg::CFG_DRY_GAIN: begin
				dry_reg = val;
			end
			fcr_pkg::CFG_WET_GAIN: begin
				wet_reg = val;
			end
			default: begin
			end
		endcase
	endtask

	// The spare index is written every time and must leave all registers alone.
	task automatic program_regs(input logic [fcr_pkg::CFG_DATA_W-1:0] tap_word, dry, wet);
		settle(SETTLE_CYCLES);
		write_reg(fcr_pkg::CFG_TAP_COUNT, tap_word);
		write_reg(fcr_pkg::CFG_DRY_GAIN, dry);
		write_reg(fcr_pkg::CFG_WET_GAIN, wet);
		write_reg(CFG_SPARE, fcr_pkg::CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Every tap in use must hold a written coefficient before a sample is sent.
	task automatic load_taps();
		int i;
		for (i = 0; i < taps_in_use(); i++) begin
			if (!coef_known[i]) begin
				send_word(fcr_pkg::REQ_COEF, fcr_pkg::SAMPLE_W'($urandom),
					fcr_pkg::COEF_IDX_W'(i), ir_word());
			end
		end
	endtask

	task automatic test_extremes();
		logic [fcr_pkg::SAMPLE_W-1:0] probes [8] = '{16'h7fff, 16'h7fff, 16'h8000,
			16'h8000, 16'h0000, 16'h0001, 16'hffff, 16'h7fff};
		int i;
		program_regs(16'd4, 16'd32768, 16'd32768);
		send_word(fcr_pkg::REQ_COEF, 16'h0000, 12'd0, 16'h7fff);
		send_word(fcr_pkg::REQ_COEF, 16'hffff, 12'd1, 16'h8000);
		send_word(fcr_pkg::REQ_COEF, 16'h0000, 12'd2, 16'h0000);
		send_word(fcr_pkg::REQ_COEF, 16'h0000, 12'd3, 16'hffff);
		send_word(fcr_pkg::REQ_COEF, 16'h0000, 12'hfff, 16'h0001);
		for (i = 0; i < 8; i++) begin
			send_word(fcr_pkg::REQ_SAMPLE, probes[i], 12'hfff, 16'hffff);
		end
	endtask

	task automatic test_gain_clamp();
		logic [fcr_pkg::GAIN_W-1:0] gains [3][2] = '{'{16'd0, 16'hffff},
			'{16'd3276, 16'd32769}, '{16'd32768, 16'd3277}};
		int i;
		for (i = 0; i < 3; i++) begin
			program_regs(16'(i + 2), gains[i][0], gains[i][1]);
			send_word(fcr_pkg::REQ_SAMPLE, 16'h7fff, 12'd0, 16'd0);
			send_word(fcr_pkg::REQ_SAMPLE, 16'h8000, 12'd0, 16'd0);
			send_word(fcr_pkg::REQ_SAMPLE, fcr_pkg::SAMPLE_W'($urandom), 12'd0, 16'd0);
		end
	endtask

	// A zero tap count acts as one, and shrinking the count below the write position
	// leaves it stale so that the next sample goes to the start of the line.
	task automatic test_tap_limits();
		int i;
		program_regs(16'he000, fcr_pkg::DRY_GAIN_RESET, fcr_pkg::WET_GAIN_RESET);
		for (i = 0; i < 3; i++) begin
			send_word(fcr_pkg::REQ_SAMPLE, fcr_pkg::SAMPLE_W'($urandom), 12'd0, 16'd0);
		end
		program_regs(16'd8, random_gain(), random_gain());
		load_taps();
		send_word(fcr_pkg::REQ_SAMPLE, 16'h7fff, 12'd0, 16'd0);
		for (i = 0; i < 4; i++) begin
			send_word(fcr_pkg::REQ_SAMPLE, fcr_pkg::SAMPLE_W'($urandom), 12'd0, 16'd0);
		end
		program_regs(16'd3, fcr_pkg::DRY_GAIN_RESET, fcr_pkg::WET_GAIN_RESET);
		send_word(fcr_pkg::REQ_SAMPLE, 16'h8000, 12'd0, 16'd0);
		send_word(fcr_pkg::REQ_SAMPLE, fcr_pkg::SAMPLE_W'($urandom), 12'd0, 16'd0);
	endtask

	task automatic test_random_round(input int src_pct, snk_pct);
		int setting;
		int k;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		for (setting = 0; setting < 2; setting++) begin
			program_regs({3'($urandom), 13'($urandom_range(48))}, random_gain(),
				random_gain());
			load_taps();
			for (k = 0; k < RANDOM_WORDS; k++) begin
				if (setting == 0 && k == RANDOM_WORDS / 2) begin
					settle(0);
				end
				if ($urandom_range(3) != 0) begin
					send_word(fcr_pkg::REQ_SAMPLE, fcr_pkg::SAMPLE_W'($urandom),
						fcr_pkg::COEF_IDX_W'($urandom), fcr_pkg::SAMPLE_W'($urandom));
				end else if ($urandom_range(1) != 0) begin
					send_word(fcr_pkg::REQ_COEF, fcr_pkg::SAMPLE_W'($urandom),
						fcr_pkg::COEF_IDX_W'($urandom_range(taps_in_use() - 1)),
						ir_word());
				end else begin
					send_word(fcr_pkg::REQ_COEF, fcr_pkg::SAMPLE_W'($urandom),
						fcr_pkg::COEF_IDX_W'($urandom), ir_word());
				end
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_extremes();
		test_gain_clamp();
		test_tap_limits();
		test_random_round(17, 86);
		test_random_round(86, 17);
		test_random_round(0, 0);
		settle(taps_in_use() + SETTLE_CYCLES);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
